@@ rtl/lrc_pkg.sv @@
// ----------------------------------------------------------------------------
// lrc_pkg: shared definitions for the LRU rate cache
// Sizes, the miss-rate table and the status bundle of the hash remainder unit.
// ----------------------------------------------------------------------------
package lrc_pkg;

    // cache geometry
    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int RANK_W  = IDX_W;

    // field widths
    localparam int KEY_W   = 32;
    localparam int HASH_W  = 32;
    localparam int RATE_W  = 9;

    // hash mod 10, two hash bits per step
    localparam int REM_W       = 4;
    localparam int HASH_STEPS  = HASH_W / 2;
    localparam int HASH_CNT_W  = $clog2(HASH_STEPS);
    localparam int MOD_BASE    = 10;

    // status of the remainder unit
    typedef struct packed {
        logic             done;
        logic [REM_W-1:0] rem;
    } t_mod_stat;

    // miss rates in hundredths, indexed by hash mod 10
    function automatic logic [RATE_W-1:0] miss_rate(input logic [REM_W-1:0] rem);
        logic [RATE_W-1:0] rate;
        case (rem)
            4'd0:    rate = 9'd272;
            4'd1:    rate = 9'd191;
            4'd2:    rate = 9'd246;
            4'd3:    rate = 9'd203;
            4'd4:    rate = 9'd112;
            4'd5:    rate = 9'd296;
            4'd6:    rate = 9'd379;
            4'd7:    rate = 9'd146;
            4'd8:    rate = 9'd266;
            4'd9:    rate = 9'd372;
            default: rate = 9'd272;
        endcase
        return rate;
    endfunction

endpackage

@@ rtl/lrc_mod10.sv @@
// ----------------------------------------------------------------------------
// lrc_mod10: serial hash remainder
// Reduces a 32-bit hash mod 10, two bits per cycle from the top.
// ----------------------------------------------------------------------------
module lrc_mod10 (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [lrc_pkg::HASH_W-1:0] i_hash,
    output lrc_pkg::t_mod_stat         o_stat
);

    logic [lrc_pkg::HASH_W-1:0]     r_bits, n_bits;
    logic [lrc_pkg::REM_W-1:0]      r_rem, n_rem;
    logic [lrc_pkg::HASH_CNT_W-1:0] r_cnt, n_cnt;
    logic                           r_busy, n_busy;
    logic                           r_done, n_done;
    logic [5:0]                     w_acc;

    // one remainder step: (4*rem + next two bits) mod 10, at most 39
    always_comb begin
        w_acc = {r_rem, r_bits[lrc_pkg::HASH_W-1 -: 2]};
        if (w_acc >= 6'd30) begin
            w_acc = w_acc - 6'd30;
        end else if (w_acc >= 6'd20) begin
            w_acc = w_acc - 6'd20;
        end else if (w_acc >= 6'(lrc_pkg::MOD_BASE)) begin
            w_acc = w_acc - 6'(lrc_pkg::MOD_BASE);
        end
    end

    // next state
    always_comb begin
        n_bits = r_bits;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = r_done;
        if (i_start) begin
            n_bits = i_hash;
            n_rem  = '0;
            n_cnt  = '0;
            n_busy = 1'b1;
            n_done = 1'b0;
        end else if (r_busy) begin
            n_bits = {r_bits[lrc_pkg::HASH_W-3:0], 2'b00};
            n_rem  = w_acc[lrc_pkg::REM_W-1:0];
            n_cnt  = r_cnt + 1'b1;
            if (r_cnt == lrc_pkg::HASH_CNT_W'(lrc_pkg::HASH_STEPS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_bits <= n_bits;
        r_rem  <= n_rem;
    end

    assign o_stat.done = r_done;
    assign o_stat.rem  = r_rem;

endmodule

@@ rtl/lru_rate_cache.sv @@
// ----------------------------------------------------------------------------
// lru_rate_cache: fully associative LRU cache of rate entries
// Looks up a key, returns the cached rate on a hit or a table rate on a miss.
// ----------------------------------------------------------------------------
// A lookup beat is taken in the idle state; then a single comparator walks
// the key, valid and rank stores entry by entry, and a finish step promotes
// the chosen entry and loads the result register. The hash mod 10 is reduced
// two bits per cycle in parallel with the walk, and the finish step waits
// for it, so below 16 entries that unit sets the lookup time. The result
// register frees the input side: a new lookup may start while the last
// result still waits. No clearing pass after reset; valid bits and ranks
// reset at once. tdata carries the key and hash in, the rate out; tuser
// carries the hit flag.
module lru_rate_cache (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // lookup beats
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [63:0] i_s_axis_tdata,   // [31:0] address_id, [63:32] address_hash
    // result beats
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // [8:0] tax_rate, [15:9] zero
    output logic [0:0]  o_m_axis_tuser    // [0] hit
);

    localparam int N  = lrc_pkg::ENTRIES;
    localparam int IW = lrc_pkg::IDX_W;
    localparam int RW = lrc_pkg::RANK_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } t_state;

    t_state r_state;

    // entry stores
    logic [lrc_pkg::KEY_W-1:0]  r_keys  [N];
    logic [lrc_pkg::RATE_W-1:0] r_rates [N];
    logic [N-1:0]               r_valid;
    logic [RW-1:0]              r_rank  [N];

    // lookup context
    logic [lrc_pkg::KEY_W-1:0]  r_key;
    logic [IW-1:0]              r_idx;
    logic                       r_found;
    logic [IW-1:0]              r_hit_idx;
    logic [lrc_pkg::RATE_W-1:0] r_hit_rate;
    logic                       r_inv_found;
    logic [IW-1:0]              r_inv_idx;
    logic [IW-1:0]              r_lru_idx;

    // result register
    logic                       r_out_valid;
    logic [lrc_pkg::RATE_W-1:0] r_out_rate;
    logic                       r_out_hit;

    lrc_pkg::t_mod_stat         w_mod;
    logic                       w_accept;
    logic                       w_finish;
    logic                       w_last;
    logic                       w_match;
    logic [IW-1:0]              w_slot;
    logic [RW-1:0]              w_old_rank;
    logic [lrc_pkg::RATE_W-1:0] w_miss_rate;
    logic [N-1:0]               w_rank0;

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_last          = (r_idx == IW'(N - 1));
    assign w_match         = r_valid[r_idx] && (r_keys[r_idx] == r_key);
    assign w_finish        = (r_state == ST_FINISH) && w_mod.done
                             && (!r_out_valid || i_m_axis_tready);

    // hash remainder runs alongside the entry walk
    lrc_mod10 u_mod10 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_accept),
        .i_hash  (i_s_axis_tdata[63:32]),
        .o_stat  (w_mod)
    );

    // target entry: hit, else first invalid, else least recent
    always_comb begin
        if (r_found) begin
            w_slot = r_hit_idx;
        end else if (r_inv_found) begin
            w_slot = r_inv_idx;
        end else begin
            w_slot = r_lru_idx;
        end
        w_old_rank  = r_rank[w_slot];
        w_miss_rate = lrc_pkg::miss_rate(w_mod.rem);
    end

    // sequencer, walk bookkeeping and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
            r_found     <= 1'b0;
            r_inv_found <= 1'b0;
        end else begin
            if (r_out_valid && i_m_axis_tready && !w_finish) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_key       <= i_s_axis_tdata[31:0];
                        r_idx       <= '0;
                        r_found     <= 1'b0;
                        r_inv_found <= 1'b0;
                        r_lru_idx   <= '0;
                        r_state     <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    // one entry per cycle through the shared comparator
                    if (w_match && !r_found) begin
                        r_found    <= 1'b1;
                        r_hit_idx  <= r_idx;
                        r_hit_rate <= r_rates[r_idx];
                    end
                    if (!r_valid[r_idx] && !r_inv_found) begin
                        r_inv_found <= 1'b1;
                        r_inv_idx   <= r_idx;
                    end
                    if (r_rank[r_idx] == RW'(N - 1)) begin
                        r_lru_idx <= r_idx;
                    end
                    if (w_last) begin
                        r_state <= ST_FINISH;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                ST_FINISH: begin
                    if (w_finish) begin
                        r_out_valid <= 1'b1;
                        r_out_hit   <= r_found;
                        r_out_rate  <= r_found ? r_hit_rate : w_miss_rate;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // valid bits and recency ranks; promotion in the finish cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            for (int i = 0; i < N; i++) begin
                r_rank[i] <= RW'(i);
            end
        end else if (w_finish) begin
            r_valid[w_slot] <= 1'b1;
            for (int i = 0; i < N; i++) begin
                if (IW'(i) == w_slot) begin
                    r_rank[i] <= '0;
                end else if (r_rank[i] < w_old_rank) begin
                    r_rank[i] <= r_rank[i] + 1'b1;
                end
            end
        end
    end

    // key and rate stores, written on a miss
    always_ff @(posedge i_clk) begin
        if (w_finish && !r_found) begin
            r_keys[w_slot]  <= r_key;
            r_rates[w_slot] <= w_miss_rate;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(16 - lrc_pkg::RATE_W){1'b0}}, r_out_rate};
    assign o_m_axis_tuser  = r_out_hit;

    // exactly one entry holds the most recent rank
    always_comb begin
        for (int i = 0; i < N; i++) begin
            w_rank0[i] = (r_rank[i] == '0);
        end
    end

    a_rank_perm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(w_rank0))
        else $error("most recent rank not held by exactly one entry");

    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mod.done |-> (w_mod.rem < lrc_pkg::REM_W'(lrc_pkg::MOD_BASE)))
        else $error("hash remainder out of range");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !o_s_axis_tready)
        else $error("lookup accepted while a walk is in progress");

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_finish |=> (o_m_axis_tvalid && (o_m_axis_tuser[0] == $past(r_found))))
        else $error("finished lookup did not load the result register");

endmodule

@@ tb/lru_rate_cache_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lru_rate_cache_tb: self-checking bench for the LRU rate cache
// Streams lookup beats into the cache and runs an in-bench model of the
// cache alongside it: the same key, rate, valid and rank stores, with
// least-recently-used replacement. Every result beat is checked against the
// oldest expected rate and hit flag. A short table of directed lookups comes
// first. It covers field extremes, every miss-rate slot, filling the cache,
// a full-cache eviction and repeated promotion. Random lookups over key pools
// of several sizes follow. Both sides of the stream stall at random.
// ----------------------------------------------------------------------------
module lru_rate_cache_tb;

    // miss rates in hundredths, slot 0 in the lowest bits
    localparam logic [10*lrc_pkg::RATE_W-1:0] TARIFF = {
        9'd372, 9'd266, 9'd146, 9'd379, 9'd296,
        9'd112, 9'd203, 9'd246, 9'd191, 9'd272
    };
    localparam int PLAN_LEN = 25;
    localparam int POOL_LEN = 48;

    typedef struct packed {
        logic [lrc_pkg::RATE_W-1:0] rate;
        logic                       hit;
    } t_rate_result;

    // one directed lookup; fixed_exp marks rows whose result is written out
    typedef struct packed {
        logic [lrc_pkg::KEY_W-1:0]  key;
        logic [lrc_pkg::HASH_W-1:0] hash;
        logic                       fixed_exp;
        logic [lrc_pkg::RATE_W-1:0] rate;
        logic                       hit;
    } t_lookup_row;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    logic [63:0]         s_tdata = '0;    // [31:0] address_id, [63:32] address_hash
    logic                m_tready = 1'b0;
    logic                o_s_axis_tready;
    logic                o_m_axis_tvalid;
    logic [15:0]         o_m_axis_tdata;  // [8:0] tax_rate, [15:9] zero
    logic [0:0]          o_m_axis_tuser;  // [0] hit

    // bench copy of the cache
    logic [lrc_pkg::KEY_W-1:0]  cache_keys  [lrc_pkg::ENTRIES];
    logic [lrc_pkg::RATE_W-1:0] cache_rates [lrc_pkg::ENTRIES];
    logic                       cache_valid [lrc_pkg::ENTRIES];
    logic [lrc_pkg::RANK_W-1:0] cache_rank  [lrc_pkg::ENTRIES];

    t_rate_result               rates_due[$];
    logic [lrc_pkg::KEY_W-1:0]  key_pool [POOL_LEN];
    int unsigned                fail_cnt = 0;
    bit                         calm = 1'b0;
    int                         stall_left = 0;

    t_lookup_row plan [PLAN_LEN] = '{
        // extremes of key and hash, hit ignores the hash
        {32'h0000_0000, 32'h0000_0000, 1'b1, 9'd272, 1'b0},
        {32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 9'd272, 1'b1},
        {32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 9'd296, 1'b0},
        // one miss for each table slot from 1 to 9, filling invalid entries in order
        {32'd1, 32'd11,          1'b1, 9'd191, 1'b0},
        {32'd2, 32'd102,         1'b1, 9'd246, 1'b0},
        {32'd3, 32'd1003,        1'b1, 9'd203, 1'b0},
        {32'd4, 32'd4,           1'b1, 9'd112, 1'b0},
        {32'd5, 32'd4294967285,  1'b1, 9'd296, 1'b0},
        {32'd6, 32'd16,          1'b1, 9'd379, 1'b0},
        {32'd7, 32'd97,          1'b1, 9'd146, 1'b0},
        {32'd8, 32'd998,         1'b1, 9'd266, 1'b0},
        {32'd9, 32'd9,           1'b1, 9'd372, 1'b0},
        // fill the rest of the cache
        {32'd10, 32'h1234_5678,  1'b0, 9'd0, 1'b0},
        {32'd11, 32'h8000_0000,  1'b0, 9'd0, 1'b0},
        {32'd12, 32'h7FFF_FFFF,  1'b0, 9'd0, 1'b0},
        {32'd13, 32'hDEAD_BEEF,  1'b0, 9'd0, 1'b0},
        {32'd14, 32'h0F0F_0F0F,  1'b0, 9'd0, 1'b0},
        // hit on the least recent entry, then evictions on a full cache
        {32'h0000_0000, 32'd5,   1'b1, 9'd272, 1'b1},
        {32'h8000_0000, 32'd10,  1'b1, 9'd272, 1'b0},
        {32'hFFFF_FFFF, 32'd0,   1'b1, 9'd272, 1'b0},
        // promote, then promote the most recent entry again
        {32'h0000_0000, 32'd3,   1'b1, 9'd272, 1'b1},
        {32'h0000_0000, 32'd7,   1'b1, 9'd272, 1'b1},
        {32'd1, 32'd1,           1'b0, 9'd0, 1'b0},
        {32'hAAAA_AAAA, 32'h5555_5555, 1'b0, 9'd0, 1'b0},
        {32'h5555_5555, 32'hAAAA_AAAA, 1'b0, 9'd0, 1'b0}
    };

    lru_rate_cache u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // run limit, several times the slowest legal run
    initial begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // model of one lookup: find, fill or evict, then promote the entry
    task automatic resolve_lookup(input logic [lrc_pkg::KEY_W-1:0] key,
                                  input logic [lrc_pkg::HASH_W-1:0] hash,
                                  output t_rate_result res);
        int                         slot;
        int unsigned                rem;
        logic [lrc_pkg::RANK_W-1:0] old_rank;
        slot = -1;
        for (int i = 0; i < lrc_pkg::ENTRIES; i++)
            if (slot < 0 && cache_valid[i] && cache_keys[i] == key) slot = i;
        if (slot >= 0) begin
            res.rate = cache_rates[slot];
            res.hit  = 1'b1;
        end else begin
            rem      = hash % lrc_pkg::MOD_BASE;
            res.rate = TARIFF[rem*lrc_pkg::RATE_W +: lrc_pkg::RATE_W];
            res.hit  = 1'b0;
            for (int i = 0; i < lrc_pkg::ENTRIES; i++)
                if (slot < 0 && !cache_valid[i]) slot = i;
            for (int i = 0; i < lrc_pkg::ENTRIES; i++)
                if (slot < 0 && cache_rank[i] == lrc_pkg::RANK_W'(lrc_pkg::ENTRIES - 1))
                    slot = i;
            if (slot < 0) slot = 0;
            cache_keys[slot]  = key;
            cache_rates[slot] = res.rate;
            cache_valid[slot] = 1'b1;
        end
        old_rank = cache_rank[slot];
        for (int i = 0; i < lrc_pkg::ENTRIES; i++)
            if (cache_rank[i] < old_rank) cache_rank[i] = cache_rank[i] + 1'b1;
        cache_rank[slot] = '0;
    endtask

    // drive one lookup beat, wait for it to be taken, queue its result
    task automatic issue_lookup(input logic [lrc_pkg::KEY_W-1:0] key,
                                input logic [lrc_pkg::HASH_W-1:0] hash,
                                input logic fixed_exp, input t_rate_result want);
        t_rate_result res;
        s_tdata  <= {hash, key};
        s_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        resolve_lookup(key, hash, res);
        rates_due.push_back(fixed_exp ? want : res);
    endtask

    // sender pause until every queued result is back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (rates_due.size() != 0) @(posedge i_clk);
    endtask

    // result side: check each beat, then pick the next ready level
    always @(posedge i_clk) begin
        t_rate_result exp_res;
        if (i_rst_n && o_m_axis_tvalid && m_tready) begin
            if (rates_due.size() == 0) begin
                $display("%0t: unexpected result beat, rate %0d hit %0d", $time,
                         o_m_axis_tdata, o_m_axis_tuser);
                fail_cnt++;
            end else begin
                exp_res = rates_due.pop_front();
                if (o_m_axis_tdata !== {7'd0, exp_res.rate}) begin
                    $display("%0t: tax_rate mismatch, expected %0d, actual %0d", $time,
                             exp_res.rate, o_m_axis_tdata);
                    fail_cnt++;
                end
                if (o_m_axis_tuser[0] !== exp_res.hit) begin
                    $display("%0t: hit mismatch, expected %0d, actual %0d", $time,
                             exp_res.hit, o_m_axis_tuser[0]);
                    fail_cnt++;
                end
            end
        end
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (!calm && $urandom_range(0, 11) == 0) begin
            stall_left = $urandom_range(1, 19) - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // main sequence
    initial begin
        int          pool_n;
        logic [31:0] key;
        for (int i = 0; i < lrc_pkg::ENTRIES; i++) begin
            cache_keys[i]  = '0;
            cache_rates[i] = '0;
            cache_valid[i] = 1'b0;
            cache_rank[i]  = lrc_pkg::RANK_W'(i);
        end
        foreach (key_pool[i]) key_pool[i] = $urandom;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        for (int r = 0; r < PLAN_LEN; r++)
            issue_lookup(plan[r].key, plan[r].hash, plan[r].fixed_exp,
                         '{rate: plan[r].rate, hit: plan[r].hit});
        drain_results();

        // random lookups: small pools mostly hit, large pools keep evicting
        for (int ph = 0; ph < 4; ph++) begin
            calm   = (ph == 3);
            pool_n = (ph == 0) ? 12 : (ph == 1) ? 20 : (ph == 2) ? POOL_LEN : 18;
            for (int n = 0; n < 400; n++) begin
                if (!calm && $urandom_range(0, 9) == 0) begin
                    s_tvalid <= 1'b0;
                    repeat ($urandom_range(1, 19)) @(posedge i_clk);
                end
                key = ($urandom_range(0, 7) == 0) ? $urandom
                                                  : key_pool[$urandom_range(0, pool_n - 1)];
                issue_lookup(key, $urandom, 1'b0, '0);
            end
            if (ph == 0) drain_results();
        end

        // let the last results come out, then idle and catch any stray beat
        drain_results();
        repeat (40) @(posedge i_clk);
        if (fail_cnt == 0 && rates_due.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
